// ----- design/spmq_pkg.sv -----
// Shared constants, codes, types and a helper function of the strict-priority multilevel queue.
package spmq_pkg;

  localparam int LEVELS      = 8;
  localparam int LEVEL_DEPTH = 16;
  localparam int ID_WIDTH    = 32;

  localparam int LVL_W       = $clog2(LEVELS);
  localparam int PTR_W       = $clog2(LEVEL_DEPTH);
  localparam int CNT_W       = $clog2(LEVEL_DEPTH + 1);
  localparam int OCC_W       = $clog2(LEVELS * LEVEL_DEPTH + 1);
  localparam int STORE_DEPTH = LEVELS * LEVEL_DEPTH;
  localparam int ADDR_W      = LVL_W + PTR_W;

  localparam int CMD_W   = 2;
  localparam int IN_ID_W = 32;
  localparam int PRIO_W  = 8;
  localparam int STAT_W  = 2;
  localparam int HLVL_W  = 3;
  localparam int TOTAL_W = 8;

  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load_rd;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rd_pending;
  } dp_stat_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] res;
    if (ptr == PTR_W'(LEVEL_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = ptr + PTR_W'(1);
    end
    return res;
  endfunction

endpackage

// ----- design/spmq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module spmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/spmq_ctrl.sv -----
// Controller state machine that sequences capture, execution and result loading.
module spmq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output spmq_pkg::ctrl_cmd_t cmd,
  input  spmq_pkg::dp_stat_t  stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   load_now;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd         = '0;
    state_nxt   = state_r;
    load_now    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd.exec = 1'b1;
          if (stat.rd_pending) begin
            state_nxt = S_READ;
          end else begin
            load_now  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_READ: begin
        cmd.load_rd = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (load_now || cmd.load_rd) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- design/spmq_dp.sv -----
// Datapath with per-level pointers and counts, the entry store and the result register.
module spmq_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  spmq_pkg::ctrl_cmd_t                  cmd,
  output spmq_pkg::dp_stat_t                   stat,
  input  logic [spmq_pkg::CMD_W-1:0]           in_command,
  input  logic [spmq_pkg::IN_ID_W-1:0]         in_entry_id,
  input  logic [spmq_pkg::PRIO_W-1:0]          in_priority_req,
  output logic [spmq_pkg::STAT_W-1:0]          out_status,
  output logic [spmq_pkg::IN_ID_W-1:0]         out_head_id,
  output logic [spmq_pkg::HLVL_W-1:0]          out_head_level,
  output logic [spmq_pkg::TOTAL_W-1:0]         out_total_count,
  output logic                                 out_all_empty
);

  logic [spmq_pkg::CMD_W-1:0]    cmd_r;
  logic [spmq_pkg::ID_WIDTH-1:0] id_r;
  logic [spmq_pkg::PRIO_W-1:0]   prio_r;

  logic [spmq_pkg::PTR_W-1:0] head_r [spmq_pkg::LEVELS];
  logic [spmq_pkg::PTR_W-1:0] head_nxt [spmq_pkg::LEVELS];
  logic [spmq_pkg::PTR_W-1:0] tail_r [spmq_pkg::LEVELS];
  logic [spmq_pkg::PTR_W-1:0] tail_nxt [spmq_pkg::LEVELS];
  logic [spmq_pkg::CNT_W-1:0] cnt_r [spmq_pkg::LEVELS];
  logic [spmq_pkg::CNT_W-1:0] cnt_nxt [spmq_pkg::LEVELS];
  logic [spmq_pkg::OCC_W-1:0] occ_r, occ_nxt;

  logic [spmq_pkg::LEVELS-1:0] nonempty;
  logic [spmq_pkg::LEVELS-1:0] full;
  logic [spmq_pkg::LVL_W-1:0]  lv_push;
  logic [spmq_pkg::LVL_W-1:0]  top;
  logic [spmq_pkg::LVL_W-1:0]  top_r;
  logic                        any_nonempty;
  logic                        is_push, is_pop, is_read;
  logic                        do_push, do_pop, do_read;

  logic [spmq_pkg::STAT_W-1:0]   status_r;
  logic [spmq_pkg::IN_ID_W-1:0]  head_id_r;
  logic [spmq_pkg::HLVL_W-1:0]   head_level_r;
  logic [spmq_pkg::TOTAL_W-1:0]  total_r;
  logic                          all_empty_r;
  logic [spmq_pkg::ID_WIDTH-1:0] rdata;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= in_command;
      id_r   <= spmq_pkg::ID_WIDTH'(in_entry_id);
      prio_r <= in_priority_req;
    end
  end

  assign lv_push = (prio_r > spmq_pkg::PRIO_W'(spmq_pkg::LEVELS - 1)) ?
                   spmq_pkg::LVL_W'(spmq_pkg::LEVELS - 1) : prio_r[spmq_pkg::LVL_W-1:0];

  always_comb begin
    top = '0;
    for (int i = 0; i < spmq_pkg::LEVELS; i++) begin
      nonempty[i] = (cnt_r[i] != '0);
      full[i]     = (cnt_r[i] == spmq_pkg::CNT_W'(spmq_pkg::LEVEL_DEPTH));
      if (nonempty[i]) begin
        top = spmq_pkg::LVL_W'(i);
      end
    end
  end

  assign any_nonempty = |nonempty;
  assign is_push      = (cmd_r == spmq_pkg::CMD_PUSH);
  assign is_pop       = (cmd_r == spmq_pkg::CMD_POP);
  assign is_read      = is_pop || (cmd_r == spmq_pkg::CMD_PEEK);

  assign stat.rd_pending = is_read && any_nonempty;

  assign do_push = cmd.exec && is_push && !full[lv_push];
  assign do_pop  = cmd.exec && is_pop && any_nonempty;
  assign do_read = cmd.exec && stat.rd_pending;

  always_comb begin
    for (int i = 0; i < spmq_pkg::LEVELS; i++) begin
      head_nxt[i] = head_r[i];
      tail_nxt[i] = tail_r[i];
      cnt_nxt[i]  = cnt_r[i];
      if (do_push && lv_push == spmq_pkg::LVL_W'(i)) begin
        tail_nxt[i] = spmq_pkg::ptr_next(tail_r[i]);
        cnt_nxt[i]  = cnt_r[i] + spmq_pkg::CNT_W'(1);
      end
      if (do_pop && top == spmq_pkg::LVL_W'(i)) begin
        head_nxt[i] = spmq_pkg::ptr_next(head_r[i]);
        cnt_nxt[i]  = cnt_r[i] - spmq_pkg::CNT_W'(1);
      end
    end
    if (do_push) begin
      occ_nxt = occ_r + spmq_pkg::OCC_W'(1);
    end else if (do_pop) begin
      occ_nxt = occ_r - spmq_pkg::OCC_W'(1);
    end else begin
      occ_nxt = occ_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < spmq_pkg::LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
      occ_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
      occ_r  <= occ_nxt;
    end
  end

  spmq_ram #(
    .WIDTH(spmq_pkg::ID_WIDTH),
    .DEPTH(spmq_pkg::STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (do_push),
    .waddr({lv_push, tail_r[lv_push]}),
    .wdata(id_r),
    .re   (do_read),
    .raddr({top, head_r[top]}),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (do_read) begin
      top_r <= top;
    end
    if (cmd.exec && !stat.rd_pending) begin
      if (is_push) begin
        status_r     <= full[lv_push] ? spmq_pkg::ST_FULL : spmq_pkg::ST_OK;
        head_level_r <= spmq_pkg::HLVL_W'(lv_push);
      end else if (is_read) begin
        status_r     <= spmq_pkg::ST_EMPTY;
        head_level_r <= '0;
      end else begin
        status_r     <= spmq_pkg::ST_OK;
        head_level_r <= '0;
      end
      head_id_r   <= '0;
      total_r     <= spmq_pkg::TOTAL_W'(occ_nxt);
      all_empty_r <= (occ_nxt == '0);
    end else if (cmd.load_rd) begin
      status_r     <= spmq_pkg::ST_OK;
      head_id_r    <= spmq_pkg::IN_ID_W'(rdata);
      head_level_r <= spmq_pkg::HLVL_W'(top_r);
      total_r      <= spmq_pkg::TOTAL_W'(occ_r);
      all_empty_r  <= (occ_r == '0);
    end
  end

  assign out_status      = status_r;
  assign out_head_id     = head_id_r;
  assign out_head_level  = head_level_r;
  assign out_total_count = total_r;
  assign out_all_empty   = all_empty_r;

endmodule

// ----- design/strict_priority_multilevel_queue.sv -----
// Top level of the strict-priority multilevel queue: controller plus datapath.
// A push, an empty pop or peek, or an unused command is captured and then executed into
// the result register; a pop or peek that finds an entry also passes the store's registered
// read. Execution waits while a held result is stalled; a new word waits for the result load.
// A word is accepted while an earlier result still waits in the output register.
// Synchronous active-low reset empties all levels at once; the store itself is not cleared.
module strict_priority_multilevel_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [spmq_pkg::CMD_W-1:0]   in_command,
  input  logic [spmq_pkg::IN_ID_W-1:0] in_entry_id,
  input  logic [spmq_pkg::PRIO_W-1:0]  in_priority_req,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [spmq_pkg::STAT_W-1:0]  out_status,
  output logic [spmq_pkg::IN_ID_W-1:0] out_head_id,
  output logic [spmq_pkg::HLVL_W-1:0]  out_head_level,
  output logic [spmq_pkg::TOTAL_W-1:0] out_total_count,
  output logic                         out_all_empty
);

  spmq_pkg::ctrl_cmd_t cmd;
  spmq_pkg::dp_stat_t  stat;

  spmq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  spmq_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_command     (in_command),
    .in_entry_id    (in_entry_id),
    .in_priority_req(in_priority_req),
    .out_status     (out_status),
    .out_head_id    (out_head_id),
    .out_head_level (out_head_level),
    .out_total_count(out_total_count),
    .out_all_empty  (out_all_empty)
  );

endmodule

// ----- design/spmq_chk.sv -----
// Port-level checker for the strict-priority multilevel queue and its bind statement.
module spmq_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [spmq_pkg::STAT_W-1:0]  out_status,
  input logic [spmq_pkg::IN_ID_W-1:0] out_head_id,
  input logic [spmq_pkg::HLVL_W-1:0]  out_head_level,
  input logic [spmq_pkg::TOTAL_W-1:0] out_total_count,
  input logic                         out_all_empty
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_head_id)
      && $stable(out_head_level) && $stable(out_total_count))
    else $error("Stalled result word changed or vanished.");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_all_empty == (out_total_count == '0))
    else $error("All-empty flag disagrees with the total count.");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == spmq_pkg::ST_EMPTY |->
      out_all_empty && out_head_id == '0 && out_head_level == '0)
    else $error("Empty status reported while entries are held.");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == spmq_pkg::ST_FULL |->
      out_head_id == '0 && out_total_count >= spmq_pkg::TOTAL_W'(spmq_pkg::LEVEL_DEPTH))
    else $error("Full status reported with fewer entries than one level holds.");

endmodule

bind strict_priority_multilevel_queue spmq_chk u_spmq_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_head_id    (out_head_id),
  .out_head_level (out_head_level),
  .out_total_count(out_total_count),
  .out_all_empty  (out_all_empty)
);

// ----- verif/tb_strict_priority_multilevel_queue.sv -----
// Self-checking testbench for the strict-priority multilevel queue with a scoreboard model.
module tb_strict_priority_multilevel_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import spmq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  localparam int N_WORDS    = 1550;
  localparam int IDLE_LIMIT = 4000;
  localparam int MAX_SHOWN  = 10;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_NOISE} phase_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [IN_ID_W-1:0] head_id;
    logic [HLVL_W-1:0]  head_level;
    logic [TOTAL_W-1:0] total;
    logic               empty;
  } qresult_t;

  class spmq_scoreboard;
    logic [IN_ID_W-1:0] level_fifo[LEVELS][$];
    int unsigned held;
    qresult_t due_q[$];
    int unsigned n_fail;

    function void flag(string what, logic [IN_ID_W-1:0] exp, logic [IN_ID_W-1:0] act);
      n_fail++;
      if (n_fail <= MAX_SHOWN) begin
        $display("mismatch in %s: expected %0h, got %0h", what, exp, act);
      end
    endfunction

    function void note_word(logic [CMD_W-1:0] cmd, logic [IN_ID_W-1:0] id,
                            logic [PRIO_W-1:0] prio);
      qresult_t r;
      int lv;
      int top;
      r = '0;
      case (cmd)
        CMD_PUSH: begin
          lv = (prio > LEVELS - 1) ? LEVELS - 1 : int'(prio);
          r.head_level = HLVL_W'(lv);
          if (level_fifo[lv].size() >= LEVEL_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            level_fifo[lv].push_back(id);
            held++;
          end
        end
        CMD_POP, CMD_PEEK: begin
          top = -1;
          for (int l = LEVELS - 1; l >= 0; l--) begin
            if (top < 0 && level_fifo[l].size() != 0) top = l;
          end
          if (top < 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.head_id = level_fifo[top][0];
            r.head_level = HLVL_W'(top);
            if (cmd == CMD_POP) begin
              void'(level_fifo[top].pop_front());
              held--;
            end
          end
        end
        default: begin
        end
      endcase
      r.total = TOTAL_W'(held);
      r.empty = (held == 0);
      due_q.push_back(r);
    endfunction

    function void check_result(qresult_t got);
      qresult_t exp;
      if (due_q.size() == 0) begin
        flag("result with no word pending", '0, got.head_id);
        return;
      end
      exp = due_q.pop_front();
      if (got.status !== exp.status)
        flag("status", IN_ID_W'(exp.status), IN_ID_W'(got.status));
      if (got.head_id !== exp.head_id) flag("head_id", exp.head_id, got.head_id);
      if (got.head_level !== exp.head_level)
        flag("head_level", IN_ID_W'(exp.head_level), IN_ID_W'(got.head_level));
      if (got.total !== exp.total)
        flag("total_count", IN_ID_W'(exp.total), IN_ID_W'(got.total));
      if (got.empty !== exp.empty)
        flag("all_empty", IN_ID_W'(exp.empty), IN_ID_W'(got.empty));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     in_command = CMD_NOP;
  logic [IN_ID_W-1:0]   in_entry_id = '0;
  logic [PRIO_W-1:0]    in_priority_req = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STAT_W-1:0]    out_status;
  logic [IN_ID_W-1:0]   out_head_id;
  logic [HLVL_W-1:0]    out_head_level;
  logic [TOTAL_W-1:0]   out_total_count;
  logic                 out_all_empty;

  spmq_scoreboard sb = new();
  bit idle_on = 1'b1;
  int idle_cycles = 0;
  int hold_left = 0;
  int calm_left = 0;
  bit calm = 1'b0;

  strict_priority_multilevel_queue DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_entry_id     (in_entry_id),
    .in_priority_req (in_priority_req),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_head_id     (out_head_id),
    .out_head_level  (out_head_level),
    .out_total_count (out_total_count),
    .out_all_empty   (out_all_empty)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_result({out_status, out_head_id, out_head_level, out_total_count,
                         out_all_empty});
      end
      if (in_valid && !in_stall) begin
        sb.note_word(in_command, in_entry_id, in_priority_req);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_hold();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  always @(posedge clk) begin
    if (calm_left == 0) begin
      calm <= ~calm;
      calm_left <= $urandom_range(50, 400);
    end else begin
      calm_left <= calm_left - 1;
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 99) < 30) begin
      hold_left <= pick_hold() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [IN_ID_W-1:0] id,
                           input logic [PRIO_W-1:0] prio);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_entry_id <= id;
    in_priority_req <= prio;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic run_directed();
    send_word(CMD_POP, 32'h0000_0000, 8'h00);
    send_word(CMD_PEEK, 32'hFFFF_FFFF, 8'hFF);
    send_word(CMD_NOP, 32'hFFFF_FFFF, 8'hFF);
    send_word(CMD_PUSH, 32'h0000_0000, 8'h00);
    send_word(CMD_PUSH, 32'hFFFF_FFFF, 8'hFF);
    send_word(CMD_PUSH, 32'h1234_5678, 8'h07);
    send_word(CMD_PUSH, 32'h8000_0001, 8'h08);
    send_word(CMD_PUSH, 32'h0000_FFFF, 8'h03);
    send_word(CMD_PEEK, 32'h5555_5555, 8'h00);
    send_word(CMD_NOP, 32'h0000_0000, 8'h00);
    send_word(CMD_POP, 32'hAAAA_AAAA, 8'hFF);
    send_word(CMD_POP, 32'h0000_0000, 8'h00);
    send_word(CMD_POP, 32'h0000_0000, 8'h00);
    send_word(CMD_POP, 32'h0000_0000, 8'h00);
    send_word(CMD_PEEK, 32'h0000_0000, 8'h00);
    send_word(CMD_POP, 32'h0000_0000, 8'h00);
    send_word(CMD_POP, 32'h0000_0000, 8'h00);
    send_word(CMD_PEEK, 32'h0000_0000, 8'h00);
  endtask

  task automatic run_random();
    phase_t kind;
    int n_sent;
    int run;
    int r;
    int lo_lv;
    int hi_lv;
    logic [CMD_W-1:0] cmd;
    logic [PRIO_W-1:0] prio;
    n_sent = 0;
    while (n_sent < N_WORDS) begin
      kind = phase_t'($urandom_range(0, 3));
      run = $urandom_range(20, 160);
      if (run > N_WORDS - n_sent) run = N_WORDS - n_sent;
      idle_on = ($urandom_range(0, 3) != 0);
      lo_lv = $urandom_range(0, LEVELS - 1);
      hi_lv = $urandom_range(lo_lv, LEVELS - 1);
      repeat (run) begin
        r = $urandom_range(0, 99);
        case (kind)
          PH_FILL: cmd = (r < 85) ? CMD_PUSH : (r < 95) ? CMD_POP : CMD_PEEK;
          PH_DRAIN: cmd = (r < 70) ? CMD_POP : (r < 85) ? CMD_PEEK : CMD_PUSH;
          PH_MIXED: cmd = (r < 45) ? CMD_PUSH : (r < 80) ? CMD_POP : CMD_PEEK;
          default: cmd = (r < 30) ? CMD_PUSH : (r < 55) ? CMD_POP : (r < 80) ? CMD_PEEK : CMD_NOP;
        endcase
        if (kind == PH_NOISE || $urandom_range(0, 99) < 10) begin
          prio = PRIO_W'($urandom_range(0, 255));
        end else begin
          prio = PRIO_W'($urandom_range(lo_lv, hi_lv));
        end
        send_word(cmd, $urandom, prio);
        n_sent++;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (sb.n_fail == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/spmq_pkg.sv
design/spmq_ram.sv
design/spmq_ctrl.sv
design/spmq_dp.sv
design/strict_priority_multilevel_queue.sv
design/spmq_chk.sv
verif/tb_strict_priority_multilevel_queue.sv
